@@ hw/rtl/swbc_pkg.sv @@
// sector write-back cache control: shared types, constants and codes
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package swbc_pkg;

   localparam int DISK_SECTORS        = 4096;
   localparam int SECTORS_PER_SECTION = 8;
   localparam int PINNED_SECTIONS     = 2;
   localparam int SECTOR_BYTES        = 512;

   localparam int LBA_W       = 12;
   localparam int SECTION_W   = 9;
   localparam int SECTOR_W    = $clog2(SECTORS_PER_SECTION);
   localparam int SLOT_W      = 4;
   localparam int INTERVAL_W  = 16;
   localparam int TIME_W      = 32;
   localparam int MAX_RESULTS = PINNED_SECTIONS + 2;
   localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);
   localparam int PTR_W       = $clog2(MAX_RESULTS);

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd10000;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_CYCLE = 2'd2,
      OP_BAD   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_REJECT = 3'd0,
      KIND_READ   = 3'd1,
      KIND_WRITE  = 3'd2,
      KIND_FLUSH  = 3'd3,
      KIND_DONE   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      SRC_PINNED = 2'd0,
      SRC_BUFFER = 2'd1,
      SRC_FLASH  = 2'd2
   } source_type;

   typedef struct packed {
      logic [1:0]            op;
      logic [LBA_W-1:0]      lba;
      logic [15:0]           byte_offset;
      logic [15:0]           transfer_size;
      logic                  forced;
      logic [TIME_W-1:0]     now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]                     kind;
      logic [1:0]                     source;
      logic [SLOT_W-1:0]              slot;
      logic [SECTION_W-1:0]           flush_section;
      logic [SECTORS_PER_SECTION-1:0] fill_mask;
      logic [9:0]                     byte_count;
      logic                           last;
   } rsp_type;

   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0] entry;
      logic [COUNT_W-1:0]        count;
   } rsp_list_type;

endpackage

@@ hw/rtl/sector_write_back_cache_control_unit.sv @@
// sector write-back cache control: top level with input register and csr
// depends on swbc_pkg, swbc_core, swbc_rsp_queue
`timescale 1ns / 1ps

// Control unit of a write-back sector cache in front of flash. Each request
// (read, write or write-cycle check) yields one to four results, the final one
// marked by last. A request is held in an input register; its results
// are then computed in a single pass and loaded into the result register,
// from which they leave one per cycle while rsp_stall is low. The next
// request is taken while the previous item's last result waits, so the
// rate is set by the number of results per item and by rsp_stall.
// csr_ready is always high; write the flush interval only while no request
// is in flight.
module sector_write_back_cache_control_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  swbc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output swbc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [swbc_pkg::INTERVAL_W-1:0]     csr_data
);
   import swbc_pkg::*;

   logic                  item_valid_ff, item_valid_in;
   req_type               item_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic                  room;
   logic                  load;
   logic                  req_take;
   rsp_list_type          list;

   assign csr_ready     = 1'b1;
   assign load          = item_valid_ff && room;
   assign req_stall     = item_valid_ff && !room;
   assign req_take      = req_valid && !req_stall;
   assign item_valid_in = req_take || (item_valid_ff && !load);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         interval_ff   <= INTERVAL_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         if (csr_valid && csr_ready) begin
            interval_ff <= csr_data;
         end
      end
      if (req_take) begin
         item_ff <= req_data;
      end
   end

   swbc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .item     (item_ff),
      .interval (interval_ff),
      .list     (list)
   );

   swbc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .list      (list),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hw/rtl/swbc_core.sv @@
// sector write-back cache control: cache state and per-item result logic
// depends on swbc_pkg
`timescale 1ns / 1ps

module swbc_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  swbc_pkg::req_type                  item,
   input  logic [swbc_pkg::INTERVAL_W-1:0]    interval,
   output swbc_pkg::rsp_list_type             list
);
   import swbc_pkg::*;

   logic [PINNED_SECTIONS-1:0]     pinned_dirty_ff, pinned_dirty_in;
   logic [SECTION_W-1:0]           buffered_section_ff, buffered_section_in;
   logic [SECTORS_PER_SECTION-1:0] sector_dirty_ff, sector_dirty_in;
   logic [TIME_W-1:0]              last_flush_ff, last_flush_in;

   always_comb begin
      logic [SECTION_W-1:0]       section;
      logic [SECTOR_W-1:0]        sector;
      logic [TIME_W-1:0]          due;
      logic                       fire;
      logic                       bad;
      logic                       pinned_hit;
      logic                       buf_flush;
      rsp_type                    base;
      rsp_type                    flush_buf;
      logic [COUNT_W-1:0]         k;

      section    = SECTION_W'(item.lba >> SECTOR_W);
      sector     = item.lba[SECTOR_W-1:0];
      due        = last_flush_ff + TIME_W'(interval);
      fire       = item.forced || (item.now_ms >= due);
      bad        = (item.op == OP_BAD) || (item.byte_offset != '0) ||
                   (32'(item.transfer_size) != SECTOR_BYTES) ||
                   (32'(item.lba) >= DISK_SECTORS);
      pinned_hit = 32'(section) < PINNED_SECTIONS;

      base       = '0;
      flush_buf  = '0;
      flush_buf.kind          = KIND_FLUSH;
      flush_buf.source        = SRC_BUFFER;
      flush_buf.flush_section = buffered_section_ff;
      flush_buf.fill_mask     = ~sector_dirty_ff;
      buf_flush  = 1'b0;

      list                = '0;
      k                   = '0;
      pinned_dirty_in     = pinned_dirty_ff;
      buffered_section_in = buffered_section_ff;
      sector_dirty_in     = sector_dirty_ff;
      last_flush_in       = last_flush_ff;

      if (item.op == OP_CYCLE) begin
         if (fire) begin
            for (int p = 0; p < PINNED_SECTIONS; p++) begin
               if (pinned_dirty_ff[p]) begin
                  list.entry[k[PTR_W-1:0]]               = '0;
                  list.entry[k[PTR_W-1:0]].kind          = KIND_FLUSH;
                  list.entry[k[PTR_W-1:0]].source        = SRC_PINNED;
                  list.entry[k[PTR_W-1:0]].flush_section = SECTION_W'(p);
                  k = k + 1'b1;
               end
            end
            if (sector_dirty_ff != '0) begin
               list.entry[k[PTR_W-1:0]] = flush_buf;
               k = k + 1'b1;
            end
            pinned_dirty_in = '0;
            sector_dirty_in = '0;
            last_flush_in   = item.now_ms;
         end
         base.kind = KIND_DONE;
         base.last = 1'b1;
         list.entry[k[PTR_W-1:0]] = base;
         list.count = k + 1'b1;
      end else if (bad) begin
         base.kind     = KIND_REJECT;
         base.last     = 1'b1;
         list.entry[0] = base;
         list.count    = COUNT_W'(1);
      end else begin
         base.byte_count = 10'(SECTOR_BYTES);
         base.last       = 1'b1;
         if (item.op == OP_READ) begin
            base.kind = KIND_READ;
            if (pinned_hit) begin
               base.source = SRC_PINNED;
               base.slot   = item.lba[SLOT_W-1:0];
            end else if (section == buffered_section_ff && sector_dirty_ff[sector]) begin
               base.source = SRC_BUFFER;
               base.slot   = SLOT_W'(sector);
            end else begin
               base.source = SRC_FLASH;
            end
         end else begin
            base.kind = KIND_WRITE;
            if (pinned_hit) begin
               base.source = SRC_PINNED;
               base.slot   = item.lba[SLOT_W-1:0];
               pinned_dirty_in[section[$clog2(PINNED_SECTIONS)-1:0]] = 1'b1;
            end else begin
               base.source = SRC_BUFFER;
               base.slot   = SLOT_W'(sector);
               if (section != buffered_section_ff) begin
                  buf_flush       = sector_dirty_ff != '0;
                  sector_dirty_in = '0;
               end
               buffered_section_in = section;
               sector_dirty_in[sector] = 1'b1;
            end
         end
         if (buf_flush) begin
            list.entry[0] = flush_buf;
            list.entry[1] = base;
            list.count    = COUNT_W'(2);
         end else begin
            list.entry[0] = base;
            list.count    = COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pinned_dirty_ff     <= '0;
         buffered_section_ff <= '0;
         sector_dirty_ff     <= '0;
         last_flush_ff       <= '0;
      end else if (load) begin
         pinned_dirty_ff     <= pinned_dirty_in;
         buffered_section_ff <= buffered_section_in;
         sector_dirty_ff     <= sector_dirty_in;
         last_flush_ff       <= last_flush_in;
      end
   end

endmodule

@@ hw/rtl/swbc_rsp_queue.sv @@
// sector write-back cache control: result register holding one item's results
// depends on swbc_pkg
`timescale 1ns / 1ps

module swbc_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  swbc_pkg::rsp_list_type  list,
   output logic                    room,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output swbc_pkg::rsp_type       rsp_data
);
   import swbc_pkg::*;

   rsp_type [MAX_RESULTS-1:0] entry_ff;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic                      pop;

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = (count_ff == '0) || (count_ff == COUNT_W'(1) && pop);

   always_comb begin
      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      if (load) begin
         count_in  = list.count;
         rd_ptr_in = '0;
      end else if (pop) begin
         count_in  = count_ff - 1'b1;
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
      end
      if (load) begin
         entry_ff <= list.entry;
      end
   end

endmodule

@@ bench/sector_write_back_cache_control_unit_tb.sv @@
// testbench for sector_write_back_cache_control_unit: directed and random requests
// with its own cache-state tracker; depends on swbc_pkg and the block's rtl
`timescale 1ns / 1ps

module sector_write_back_cache_control_unit_tb;
   import swbc_pkg::*;

   class cache_state_tracker;
      logic [INTERVAL_W-1:0]          flush_interval = INTERVAL_RESET;
      logic [PINNED_SECTIONS-1:0]     pinned_dirty = '0;
      logic [SECTION_W-1:0]           buffered_section = '0;
      logic [SECTORS_PER_SECTION-1:0] sector_dirty = '0;
      logic [TIME_W-1:0]              last_flush_ms = '0;
      rsp_type                        due_results[$];
      int requests = 0;
      int results = 0;
      int flushes = 0;
      int rejects = 0;
      int errors = 0;

      function int pending();
         return due_results.size();
      endfunction

      function void set_interval(logic [INTERVAL_W-1:0] value);
         flush_interval = value;
      endfunction

      function void add_result(kind_type kind, source_type source, logic [SLOT_W-1:0] slot,
                               logic [SECTION_W-1:0] section,
                               logic [SECTORS_PER_SECTION-1:0] fill, logic [9:0] bytes,
                               logic last);
         rsp_type r;
         r.kind = kind;
         r.source = source;
         r.slot = slot;
         r.flush_section = section;
         r.fill_mask = fill;
         r.byte_count = bytes;
         r.last = last;
         due_results.push_back(r);
         if (kind == KIND_FLUSH) flushes++;
         if (kind == KIND_REJECT) rejects++;
      endfunction

      function void flush_buffer();
         if (sector_dirty != 0) begin
            add_result(KIND_FLUSH, SRC_BUFFER, 0, buffered_section, ~sector_dirty, 0, 1'b0);
            sector_dirty = '0;
         end
      endfunction

      function void take_request(req_type r);
         logic [TIME_W-1:0]    due;
         logic [SECTION_W-1:0] section;
         logic [SECTOR_W-1:0]  sector;
         requests++;
         section = SECTION_W'(r.lba >> SECTOR_W);
         sector = r.lba[SECTOR_W-1:0];
         if (r.op == OP_CYCLE) begin
            due = last_flush_ms + TIME_W'(flush_interval);
            if (r.forced || r.now_ms >= due) begin
               last_flush_ms = r.now_ms;
               for (int p = 0; p < PINNED_SECTIONS; p++)
                  if (pinned_dirty[p])
                     add_result(KIND_FLUSH, SRC_PINNED, 0, SECTION_W'(p), 0, 0, 1'b0);
               pinned_dirty = '0;
               flush_buffer();
            end
            add_result(KIND_DONE, SRC_PINNED, 0, 0, 0, 0, 1'b1);
         end else if (r.op == OP_BAD || r.byte_offset != 0 || r.transfer_size != SECTOR_BYTES
                      || r.lba >= DISK_SECTORS) begin
            add_result(KIND_REJECT, SRC_PINNED, 0, 0, 0, 0, 1'b1);
         end else if (r.op == OP_READ) begin
            if (section < PINNED_SECTIONS)
               add_result(KIND_READ, SRC_PINNED, r.lba[SLOT_W-1:0], 0, 0,
                          10'(SECTOR_BYTES), 1'b1);
            else if (section == buffered_section && sector_dirty[sector])
               add_result(KIND_READ, SRC_BUFFER, SLOT_W'(sector), 0, 0,
                          10'(SECTOR_BYTES), 1'b1);
            else
               add_result(KIND_READ, SRC_FLASH, 0, 0, 0, 10'(SECTOR_BYTES), 1'b1);
         end else if (section < PINNED_SECTIONS) begin
            pinned_dirty[section[0]] = 1'b1;
            add_result(KIND_WRITE, SRC_PINNED, r.lba[SLOT_W-1:0], 0, 0,
                       10'(SECTOR_BYTES), 1'b1);
         end else begin
            if (section != buffered_section) flush_buffer();
            buffered_section = section;
            sector_dirty[sector] = 1'b1;
            add_result(KIND_WRITE, SRC_BUFFER, SLOT_W'(sector), 0, 0,
                       10'(SECTOR_BYTES), 1'b1);
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results++;
         if (due_results.size() == 0) begin
            $error("result with nothing outstanding, kind %0d", got.kind);
            errors++;
            return;
         end
         want = due_results.pop_front();
         compare_field("kind", 32'(want.kind), 32'(got.kind));
         compare_field("source", 32'(want.source), 32'(got.source));
         compare_field("slot", 32'(want.slot), 32'(got.slot));
         compare_field("flush_section", 32'(want.flush_section), 32'(got.flush_section));
         compare_field("fill_mask", 32'(want.fill_mask), 32'(got.fill_mask));
         compare_field("byte_count", 32'(want.byte_count), 32'(got.byte_count));
         compare_field("last", 32'(want.last), 32'(got.last));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [INTERVAL_W-1:0] csr_data;

   cache_state_tracker   tracker = new;
   int                   req_idle_max = 7;
   int                   rsp_idle_max = 7;
   int                   hold_cycles = 0;
   int                   input_stalls = 0;
   int                   interval_writes = 0;
   logic [TIME_W-1:0]    ms_clock = '0;
   logic [SECTION_W-1:0] hot_section [3];

   sector_write_back_cache_control_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   function req_type access(op_type op, logic [LBA_W-1:0] lba);
      req_type item;
      item.op = op;
      item.lba = lba;
      item.byte_offset = '0;
      item.transfer_size = 16'(SECTOR_BYTES);
      item.forced = 1'($urandom);
      item.now_ms = $urandom;
      return item;
   endfunction

   function req_type cycle_check(logic forced, logic [TIME_W-1:0] now);
      req_type item;
      item.op = OP_CYCLE;
      item.lba = LBA_W'($urandom);
      item.byte_offset = 16'($urandom);
      item.transfer_size = 16'($urandom);
      item.forced = forced;
      item.now_ms = now;
      return item;
   endfunction

   function logic [LBA_W-1:0] pick_lba();
      int choice;
      choice = $urandom_range(0, 9);
      if (choice < 3)
         return LBA_W'($urandom_range(0, PINNED_SECTIONS * SECTORS_PER_SECTION - 1));
      if (choice < 8)
         return {hot_section[$urandom_range(0, 2)],
                 SECTOR_W'($urandom_range(0, SECTORS_PER_SECTION - 1))};
      return LBA_W'($urandom_range(0, DISK_SECTORS - 1));
   endfunction

   task send_request(input req_type item);
      int gap;
      gap = $urandom_range(0, req_idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) begin
         input_stalls++;
         @(posedge clock);
      end
      tracker.take_request(item);
      @(negedge clock);
   endtask

   task write_interval(input logic [INTERVAL_W-1:0] value);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_interval(value);
      interval_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task run_random(input int count);
      int          choice;
      logic [15:0] size;
      req_type     item;
      foreach (hot_section[i])
         hot_section[i] = SECTION_W'($urandom_range(PINNED_SECTIONS, 511));
      repeat (count) begin
         choice = $urandom_range(0, 99);
         if (choice < 8) begin
            item = access(op_type'($urandom_range(OP_READ, OP_WRITE)), LBA_W'($urandom));
            case ($urandom_range(0, 3))
               0: item.op = OP_BAD;
               1: item.byte_offset = 16'($urandom_range(1, 65535));
               2: begin
                  size = 16'($urandom);
                  if (size == SECTOR_BYTES) size = '0;
                  item.transfer_size = size;
               end
               default: begin
                  item.op = op_type'($urandom_range(0, 3));
                  item.byte_offset = 16'($urandom);
                  item.transfer_size = 16'($urandom);
               end
            endcase
         end else if (choice < 43) begin
            item = access(OP_READ, pick_lba());
         end else if (choice < 83) begin
            item = access(OP_WRITE, pick_lba());
         end else begin
            if ($urandom_range(0, 19) == 0) ms_clock = $urandom;
            else ms_clock += $urandom_range(0, 2 * tracker.flush_interval + 50);
            item = cycle_check($urandom_range(0, 3) == 0, ms_clock);
         end
         send_request(item);
      end
   endtask

   // result side: random stalls per transfer, plus one long hold-off on request
   initial begin : result_sink
      int wait_cycles;
      rsp_stall = 1'b0;
      wait (reset === 1'b1);
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         wait_cycles = (hold_cycles > 0) ? hold_cycles : $urandom_range(0, rsp_idle_max);
         hold_cycles = 0;
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         tracker.check_result(rsp_data);
         @(negedge clock);
      end
   end

   initial begin
      req_type item;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: pinned, buffer and flash paths, flushes, time wrap, rejects
      send_request(access(OP_READ, 12'd0));
      send_request(access(OP_READ, 12'd15));
      send_request(access(OP_READ, 12'd4095));
      send_request(access(OP_WRITE, 12'd3));
      send_request(access(OP_WRITE, 12'd12));
      send_request(access(OP_WRITE, 12'd16));
      send_request(access(OP_WRITE, 12'd23));
      send_request(access(OP_READ, 12'd16));
      send_request(access(OP_READ, 12'd17));
      send_request(access(OP_WRITE, 12'd4095));
      send_request(access(OP_READ, 12'd4095));
      send_request(access(OP_READ, 12'd4088));
      send_request(cycle_check(1'b0, 32'd5));
      send_request(cycle_check(1'b1, 32'hFFFF_FFFF));
      send_request(access(OP_WRITE, 12'd8));
      send_request(cycle_check(1'b0, 32'd5));
      send_request(cycle_check(1'b0, 32'd9999));
      item = access(OP_READ, 12'd40);
      item.byte_offset = 16'hFFFF;
      send_request(item);
      item = access(OP_WRITE, 12'd41);
      item.byte_offset = 16'd1;
      send_request(item);
      item = access(OP_READ, 12'd42);
      item.transfer_size = 16'd0;
      send_request(item);
      item = access(OP_WRITE, 12'd43);
      item.transfer_size = 16'hFFFF;
      send_request(item);
      item = access(OP_READ, 12'd44);
      item.transfer_size = 16'(SECTOR_BYTES - 1);
      send_request(item);
      item = access(OP_READ, 12'd0);
      item.op = OP_BAD;
      send_request(item);
      send_request(cycle_check(1'b1, 32'd0));

      run_random(60);

      write_interval('0);
      req_idle_max = 0;
      rsp_idle_max = 0;
      run_random(60);

      write_interval('1);
      rsp_idle_max = 7;
      run_random(60);

      // long receiver hold-off while requests keep coming
      hold_cycles = 90;
      run_random(25);

      write_interval(INTERVAL_W'($urandom));
      req_idle_max = 7;
      rsp_idle_max = 0;
      run_random(60);

      write_interval(16'd1000);
      rsp_idle_max = 7;
      run_random(40);

      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (12) @(negedge clock);

      $display("covered %0d requests and %0d results (%0d flushes, %0d rejects), %0d intervals",
               tracker.requests, tracker.results, tracker.flushes, tracker.rejects,
               interval_writes);
      $display("input side held back for %0d cycles by result back-pressure", input_stalls);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
